### src/pbrq_pkg.sv
// ---------------------------------------------------------------------------
// pbrq_pkg
// Shared types and constants for the priority bitmap ready queue.
// ---------------------------------------------------------------------------
`default_nettype none

package pbrq_pkg;

    // default sizes
    localparam int MAX_TASKS_DEF = 64;
    localparam int LEVELS_DEF    = 32;

    // field widths
    localparam int TASK_W    = 6;
    localparam int LEVEL_W   = 5;
    localparam int SLICE_W   = 32;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
    localparam logic [OP_W-1:0] OP_CHANGE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TASK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_RELOAD = 2'd2;

    // configuration reset values
    localparam logic [TASK_W-1:0] IDLE_TASK_RST    = 6'd0;
    localparam logic [CFG_W-1:0]  SLICE_MIN_RST    = 31'd0;
    localparam logic [CFG_W-1:0]  SLICE_RELOAD_RST = 31'd1000;

    // configuration seen by the controller
    typedef struct packed {
        logic [TASK_W-1:0] idle_task;
        logic [CFG_W-1:0]  slice_minimum;
        logic [CFG_W-1:0]  slice_reload;
    } cfg_t;

endpackage

`default_nettype wire

### src/pbrq_if.sv
// ---------------------------------------------------------------------------
// pbrq_if
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface pbrq_req_if
    import pbrq_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [TASK_W-1:0]         task_req;
    logic [LEVEL_W-1:0]        level;
    logic signed [SLICE_W-1:0] slice_in;

    modport source (output valid, output operation, output task_req, output level,
                    output slice_in, input ready);
    modport sink   (input valid, input operation, input task_req, input level,
                    input slice_in, output ready);
endinterface

interface pbrq_rsp_if
    import pbrq_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic [TASK_W-1:0]         top_task;
    logic                      top_is_idle;
    logic signed [SLICE_W-1:0] slice_out;
    logic                      was_ready;
    logic                      error;

    modport source (output valid, output top_task, output top_is_idle, output slice_out,
                    output was_ready, output error, input ready);
    modport sink   (input valid, input top_task, input top_is_idle, input slice_out,
                    input was_ready, input error, output ready);
endinterface

`default_nettype wire

### src/pbrq_ram.sv
// ---------------------------------------------------------------------------
// pbrq_ram
// Single write port, single read port memory with bit write mask and
// registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pbrq_ram
    import pbrq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wmask,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // masked write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                if (wmask[i])
                begin
                    mem[waddr][i] <= wdata[i];
                end
            end
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/pbrq_ctrl.sv
// ---------------------------------------------------------------------------
// pbrq_ctrl
// Sequencer that walks each operation through read, modify and write of the
// task link memory and the level head/tail memory, then reports the top task.
// ---------------------------------------------------------------------------
`default_nettype none

module pbrq_ctrl
    import pbrq_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int LEVELS    = LEVELS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    pbrq_req_if.sink   req,
    pbrq_rsp_if.source rsp
);

    localparam int AW    = $clog2(MAX_TASKS);
    localparam int LW    = $clog2(MAX_TASKS + 1);
    localparam int LVW   = $clog2(LEVELS);
    localparam int TM_W  = 2 * LW + LVW;
    localparam int LM_W  = 2 * TASK_W;

    localparam logic [LW-1:0]   NO_LINK = LW'(MAX_TASKS);
    localparam logic [TM_W-1:0] M_NEXT  = {{LW{1'b1}}, {LW{1'b0}}, {LVW{1'b0}}};
    localparam logic [TM_W-1:0] M_PREV  = {{LW{1'b0}}, {LW{1'b1}}, {LVW{1'b0}}};
    localparam logic [TM_W-1:0] M_LVL   = {{LW{1'b0}}, {LW{1'b0}}, {LVW{1'b1}}};
    localparam logic [TM_W-1:0] M_ALL   = {TM_W{1'b1}};
    localparam logic [LM_W-1:0] M_HEAD  = {{TASK_W{1'b1}}, {TASK_W{1'b0}}};
    localparam logic [LM_W-1:0] M_TAIL  = {{TASK_W{1'b0}}, {TASK_W{1'b1}}};

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_UNL1   = 4'd2;
    localparam logic [3:0] S_UNL2   = 4'd3;
    localparam logic [3:0] S_ENQ    = 4'd4;
    localparam logic [3:0] S_LNK1   = 4'd5;
    localparam logic [3:0] S_LNK2   = 4'd6;
    localparam logic [3:0] S_TOP    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [MAX_TASKS-1:0]      ready_reg, ready_next;
    logic [LEVELS-1:0]         map_reg, map_next;
    logic                      out_valid_reg, out_valid_next;

    logic [OP_W-1:0]           op_reg, op_next;
    logic [TASK_W-1:0]         t_reg, t_next;
    logic [LVW-1:0]            lv_reg, lv_next;
    logic [SLICE_W-1:0]        slice_reg, slice_next;
    logic [SLICE_W-1:0]        res_slice_reg, res_slice_next;
    logic                      was_reg, was_next;
    logic                      err_reg, err_next;
    logic                      head_mode_reg, head_mode_next;
    logic                      relink_reg, relink_next;
    logic [TASK_W-1:0]         nb_reg, nb_next;
    logic [LW-1:0]             un_next_reg, un_next_next;
    logic [LW-1:0]             un_prev_reg, un_prev_next;
    logic [TASK_W-1:0]         out_top_reg, out_top_next;
    logic                      out_idle_reg, out_idle_next;
    logic [SLICE_W-1:0]        out_slice_reg, out_slice_next;
    logic                      out_was_reg, out_was_next;
    logic                      out_err_reg, out_err_next;

    // memory ports
    logic            tm_we, tm_re;
    logic [AW-1:0]   tm_waddr;
    logic [TM_W-1:0] tm_wmask, tm_rdata;
    logic [LW-1:0]   w_next, w_prev;
    logic [LVW-1:0]  w_lvl;
    logic            lm_we, lm_re;
    logic [LVW-1:0]  lm_waddr, lm_raddr;
    logic [LM_W-1:0] lm_wmask, lm_wdata, lm_rdata;

    logic [AW-1:0]     ti;
    logic              t_ok, t_is_idle, cur_ready, head_go, any_ne;
    logic [LW-1:0]     td_next, td_prev;
    logic [LVW-1:0]    td_level;
    logic [TASK_W-1:0] ld_head, ld_tail;
    logic [LVW-1:0]    top_lv;
    logic              pv, nv;

    // link memory: {next, prev, level} per task
    pbrq_ram #(.WIDTH(TM_W), .DEPTH(MAX_TASKS)) u_task_mem (
        .clk   (clk),
        .we    (tm_we),
        .waddr (tm_waddr),
        .wmask (tm_wmask),
        .wdata ({w_next, w_prev, w_lvl}),
        .re    (tm_re),
        .raddr (ti),
        .rdata (tm_rdata)
    );

    // level memory: {head, tail} per level
    pbrq_ram #(.WIDTH(LM_W), .DEPTH(LEVELS)) u_level_mem (
        .clk   (clk),
        .we    (lm_we),
        .waddr (lm_waddr),
        .wmask (lm_wmask),
        .wdata (lm_wdata),
        .re    (lm_re),
        .raddr (lm_raddr),
        .rdata (lm_rdata)
    );

    // decode of the held transaction and memory read data
    assign ti        = AW'(t_reg);
    assign t_ok      = 32'(t_reg) < 32'(MAX_TASKS);
    assign t_is_idle = (t_reg == cfg.idle_task);
    assign cur_ready = ready_reg[ti];
    assign head_go   = $signed(slice_reg) > $signed({1'b0, cfg.slice_minimum});
    assign td_next   = tm_rdata[TM_W-1 -: LW];
    assign td_prev   = tm_rdata[LVW +: LW];
    assign td_level  = tm_rdata[LVW-1:0];
    assign ld_head   = lm_rdata[LM_W-1 -: TASK_W];
    assign ld_tail   = lm_rdata[TASK_W-1:0];
    assign pv        = td_prev < NO_LINK;
    assign nv        = td_next < NO_LINK;

    // lowest-numbered non-empty level
    always_comb
    begin
        top_lv = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (map_reg[l])
            begin
                top_lv = LVW'(l);
            end
        end
    end
    assign any_ne = |map_reg;

    // read enables and addresses
    assign tm_re    = (state_reg == S_DECIDE);
    assign lm_re    = (state_reg == S_ENQ) || (state_reg == S_TOP);
    assign lm_raddr = (state_reg == S_TOP) ? top_lv : lv_reg;

    // handshake
    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.top_task    = out_top_reg;
    assign rsp.top_is_idle = out_idle_reg;
    assign rsp.slice_out   = out_slice_reg;
    assign rsp.was_ready   = out_was_reg;
    assign rsp.error       = out_err_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ready_next     = ready_reg;
        map_next       = map_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        op_next        = op_reg;
        t_next         = t_reg;
        lv_next        = lv_reg;
        slice_next     = slice_reg;
        res_slice_next = res_slice_reg;
        was_next       = was_reg;
        err_next       = err_reg;
        head_mode_next = head_mode_reg;
        relink_next    = relink_reg;
        nb_next        = nb_reg;
        un_next_next   = un_next_reg;
        un_prev_next   = un_prev_reg;
        out_top_next   = out_top_reg;
        out_idle_next  = out_idle_reg;
        out_slice_next = out_slice_reg;
        out_was_next   = out_was_reg;
        out_err_next   = out_err_reg;
        tm_we          = 1'b0;
        tm_waddr       = ti;
        tm_wmask       = '0;
        w_next         = NO_LINK;
        w_prev         = NO_LINK;
        w_lvl          = lv_reg;
        lm_we          = 1'b0;
        lm_waddr       = lv_reg;
        lm_wmask       = '0;
        lm_wdata       = {t_reg, t_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.operation;
                    t_next         = req.task_req;
                    lv_next        = (32'(req.level) >= 32'(LEVELS)) ? LVW'(LEVELS - 1)
                                                                      : LVW'(req.level);
                    slice_next     = req.slice_in;
                    res_slice_next = req.slice_in;
                    was_next       = 1'b0;
                    err_next       = 1'b0;
                    state_next     = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = S_TOP;
                if (t_ok)
                begin
                    was_next = cur_ready;
                    case (op_reg)
                        OP_ENQUEUE:
                        begin
                            if (cur_ready)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ENQ;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cur_ready)
                            begin
                                ready_next[ti] = 1'b0;
                                if (!t_is_idle)
                                begin
                                    relink_next = 1'b0;
                                    state_next  = S_UNL1;
                                end
                            end
                        end
                        OP_CHANGE:
                        begin
                            if (cur_ready)
                            begin
                                ready_next[ti] = 1'b0;
                                relink_next    = 1'b1;
                                state_next     = t_is_idle ? S_ENQ : S_UNL1;
                            end
                            else
                            begin
                                // only record the new level
                                tm_we    = 1'b1;
                                tm_wmask = M_LVL;
                            end
                        end
                        default:
                        begin
                            state_next = S_TOP;
                        end
                    endcase
                end
            end

            S_UNL1:
            begin
                // bypass the task on its predecessor side, fix head and tail
                lm_waddr = td_level;
                lm_wdata = {(nv ? TASK_W'(td_next) : TASK_W'(0)),
                            (pv ? TASK_W'(td_prev) : TASK_W'(0))};
                lm_wmask = (pv ? '0 : M_HEAD) | (nv ? '0 : M_TAIL);
                lm_we    = !pv || !nv;
                if (pv)
                begin
                    tm_we    = 1'b1;
                    tm_waddr = AW'(td_prev);
                    tm_wmask = M_NEXT;
                    w_next   = td_next;
                end
                if (!pv && !nv)
                begin
                    map_next[td_level] = 1'b0;
                end
                un_next_next = td_next;
                un_prev_next = td_prev;
                state_next   = S_UNL2;
            end

            S_UNL2:
            begin
                // successor side of the unlink
                if (un_next_reg < NO_LINK)
                begin
                    tm_we    = 1'b1;
                    tm_waddr = AW'(un_next_reg);
                    tm_wmask = M_PREV;
                    w_prev   = un_prev_reg;
                end
                state_next = relink_reg ? S_ENQ : S_TOP;
            end

            S_ENQ:
            begin
                ready_next[ti] = 1'b1;
                if (t_is_idle)
                begin
                    tm_we      = 1'b1;
                    tm_wmask   = M_LVL;
                    state_next = S_TOP;
                end
                else
                begin
                    head_mode_next = head_go;
                    res_slice_next = head_go ? slice_reg
                                             : {1'b0, cfg.slice_reload};
                    if (!map_reg[lv_reg])
                    begin
                        // first task of an empty level
                        tm_we            = 1'b1;
                        tm_wmask         = M_ALL;
                        lm_we            = 1'b1;
                        lm_wmask         = M_HEAD | M_TAIL;
                        map_next[lv_reg] = 1'b1;
                        state_next       = S_TOP;
                    end
                    else
                    begin
                        state_next = S_LNK1;
                    end
                end
            end

            S_LNK1:
            begin
                // write the new task's links and move head or tail
                tm_we    = 1'b1;
                tm_wmask = M_ALL;
                lm_we    = 1'b1;
                if (head_mode_reg)
                begin
                    w_next   = LW'(ld_head);
                    lm_wmask = M_HEAD;
                    nb_next  = ld_head;
                end
                else
                begin
                    w_prev   = LW'(ld_tail);
                    lm_wmask = M_TAIL;
                    nb_next  = ld_tail;
                end
                state_next = S_LNK2;
            end

            S_LNK2:
            begin
                // point the old head or tail at the new task
                if (32'(nb_reg) < 32'(MAX_TASKS))
                begin
                    tm_we    = 1'b1;
                    tm_waddr = AW'(nb_reg);
                    tm_wmask = head_mode_reg ? M_PREV : M_NEXT;
                    w_next   = LW'(t_reg);
                    w_prev   = LW'(t_reg);
                end
                state_next = S_TOP;
            end

            S_TOP:
            begin
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_top_next   = any_ne ? ld_head : cfg.idle_task;
                    out_idle_next  = !any_ne;
                    out_slice_next = res_slice_reg;
                    out_was_next   = was_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= '0;
            map_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            map_reg       <= map_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transaction payload
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        t_reg         <= t_next;
        lv_reg        <= lv_next;
        slice_reg     <= slice_next;
        res_slice_reg <= res_slice_next;
        was_reg       <= was_next;
        err_reg       <= err_next;
        head_mode_reg <= head_mode_next;
        relink_reg    <= relink_next;
        nb_reg        <= nb_next;
        un_next_reg   <= un_next_next;
        un_prev_reg   <= un_prev_next;
        out_top_reg   <= out_top_next;
        out_idle_reg  <= out_idle_next;
        out_slice_reg <= out_slice_next;
        out_was_reg   <= out_was_next;
        out_err_reg   <= out_err_next;
    end

endmodule

`default_nettype wire

### src/priority_bitmap_ready_queue_top.sv
// A query or rejected operation goes through decide, top and output. An enqueue adds
// the enqueue state and, on a non-empty level, the link states; a change of priority
// of a queued task unlinks it first. One transaction at a time, set by the
// read-modify-write sequence on the single-write-port link memory.
// Reset: ready flags and the level bitmap clear at once; link memories are not
// cleared and need no pass; configuration returns to idle 0, minimum 0, reload 1000.
// ---------------------------------------------------------------------------
// priority_bitmap_ready_queue_top
// Ready queues of a priority scheduler with configuration registers.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_bitmap_ready_queue_top
    import pbrq_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int LEVELS    = LEVELS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    pbrq_req_if.sink                  req,
    pbrq_rsp_if.source                rsp
);

    logic [TASK_W-1:0] idle_task_reg;
    logic [CFG_W-1:0]  slice_minimum_reg;
    logic [CFG_W-1:0]  slice_reload_reg;
    cfg_t              cfg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_task_reg     <= IDLE_TASK_RST;
            slice_minimum_reg <= SLICE_MIN_RST;
            slice_reload_reg  <= SLICE_RELOAD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDLE_TASK:    idle_task_reg     <= cfg_data[TASK_W-1:0];
                CFG_SLICE_MIN:    slice_minimum_reg <= cfg_data;
                CFG_SLICE_RELOAD: slice_reload_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg = '{idle_task:     idle_task_reg,
                   slice_minimum: slice_minimum_reg,
                   slice_reload:  slice_reload_reg};

    // sequencer with link memories
    pbrq_ctrl #(.MAX_TASKS(MAX_TASKS), .LEVELS(LEVELS)) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    // one transaction in flight at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while a transaction is in flight");

    // an error only comes from a task that was already ready
    a_error_was_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.error |-> rsp.was_ready)
        else $error("error flagged for a task that was not ready");

    // empty queues report the idle task
    a_idle_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.top_is_idle |-> rsp.top_task == idle_task_reg)
        else $error("empty queues did not report the idle task");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority bitmap ready queue. A local copy of
// the ready queues predicts every response, which is checked field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import pbrq_pkg::*;

    localparam int NTASK    = 64;
    localparam int NLEVEL   = 32;
    localparam int NONE     = 64;
    localparam int STALL_MAX = 5000;

    typedef struct {
        logic [TASK_W-1:0]         top_task;
        logic                      top_is_idle;
        logic signed [SLICE_W-1:0] slice_out;
        logic                      was_ready;
        logic                      error;
    } resp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pbrq_req_if req_ch ();
    pbrq_rsp_if rsp_ch ();

    priority_bitmap_ready_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // shadow of the ready queues
    int                  nxt_q [NTASK];
    int                  prv_q [NTASK];
    int                  lvl_of [NTASK];
    bit                  is_rdy [NTASK];
    int                  head_q [NLEVEL];
    int                  tail_q [NLEVEL];
    bit [31:0]           busy_map;
    logic [TASK_W-1:0]   idle_id;
    logic [CFG_W-1:0]    min_slice;
    logic [CFG_W-1:0]    reload_slice;

    resp_t pending_resp [$];
    int    n_errors;
    int    n_sent;
    int    n_checked;
    int    n_err_flags;
    int    hold_cycles;
    bit    no_idling;
    int    quiet_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic void link_at_head(int t, int lv);
        if (!busy_map[31-lv])
        begin
            head_q[lv] = t;
            tail_q[lv] = t;
            nxt_q[t] = NONE;
            prv_q[t] = NONE;
            busy_map[31-lv] = 1'b1;
        end
        else
        begin
            nxt_q[t] = head_q[lv];
            prv_q[t] = NONE;
            prv_q[head_q[lv]] = t;
            head_q[lv] = t;
        end
    endfunction

    function automatic void link_at_tail(int t, int lv);
        if (!busy_map[31-lv])
            link_at_head(t, lv);
        else
        begin
            prv_q[t] = tail_q[lv];
            nxt_q[t] = NONE;
            nxt_q[tail_q[lv]] = t;
            tail_q[lv] = t;
        end
    endfunction

    function automatic void unlink(int t, int lv);
        int p;
        int n;
        p = prv_q[t];
        n = nxt_q[t];
        if (p < NONE) nxt_q[p] = n;
        else head_q[lv] = (n < NONE) ? n : 0;
        if (n < NONE) prv_q[n] = p;
        else tail_q[lv] = (p < NONE) ? p : 0;
        if (p >= NONE && n >= NONE) busy_map[31-lv] = 1'b0;
    endfunction

    // make a task ready; returns the slice to report
    function automatic logic signed [31:0] make_ready(int t, int lv, logic signed [31:0] s);
        logic signed [31:0] res;
        longint sv;
        longint mv;
        res = s;
        sv = longint'(s);
        mv = longint'(min_slice);
        if (t != idle_id)
        begin
            if (sv > mv)
                link_at_head(t, lv);
            else
            begin
                res = {1'b0, reload_slice};
                link_at_tail(t, lv);
            end
        end
        is_rdy[t] = 1'b1;
        return res;
    endfunction

    function automatic resp_t predict_queue_op(logic [OP_W-1:0] op, int t, int lv,
                                               logic signed [31:0] s);
        resp_t r;
        r.slice_out = s;
        r.was_ready = is_rdy[t];
        r.error = 1'b0;
        if (op == OP_ENQUEUE)
        begin
            if (is_rdy[t])
                r.error = 1'b1;
            else
            begin
                lvl_of[t] = lv;
                r.slice_out = make_ready(t, lv, s);
            end
        end
        else if (op == OP_REMOVE)
        begin
            if (is_rdy[t])
            begin
                if (t != idle_id) unlink(t, lvl_of[t]);
                is_rdy[t] = 1'b0;
            end
        end
        else if (op == OP_CHANGE)
        begin
            if (is_rdy[t])
            begin
                if (t != idle_id) unlink(t, lvl_of[t]);
                is_rdy[t] = 1'b0;
                lvl_of[t] = lv;
                r.slice_out = make_ready(t, lv, s);
            end
            else
                lvl_of[t] = lv;
        end
        r.top_task = idle_id;
        r.top_is_idle = 1'b1;
        for (int l = 0; l < NLEVEL; l++)
        begin
            if (busy_map[31-l])
            begin
                r.top_task = head_q[l][TASK_W-1:0];
                r.top_is_idle = 1'b0;
                break;
            end
        end
        return r;
    endfunction

    // drive one request and record its expected response
    task automatic send_op(logic [OP_W-1:0] op, int t, int lv, logic signed [31:0] s);
        if (!no_idling && $urandom_range(99) < 22)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid = 1'b1;
        req_ch.operation = op;
        req_ch.task_req = t[TASK_W-1:0];
        req_ch.level = lv[LEVEL_W-1:0];
        req_ch.slice_in = s;
        do @(posedge clk); while (!req_ch.ready);
        pending_resp.push_back(predict_queue_op(op, t, lv, s));
        if (op == OP_ENQUEUE && is_rdy[t] && pending_resp[$].error) n_err_flags++;
        n_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_resp.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // take every ready task out so the idle identifier can move safely
    task automatic clear_ready_tasks();
        for (int t = 0; t < NTASK; t++)
            if (is_rdy[t]) send_op(OP_REMOVE, t, 0, 0);
        wait_drained();
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_IDLE_TASK) idle_id = val[TASK_W-1:0];
        else if (idx == CFG_SLICE_MIN) min_slice = val;
        else if (idx == CFG_SLICE_RELOAD) reload_slice = val;
    endtask

    task automatic set_config(int idle, logic [CFG_W-1:0] mn, logic [CFG_W-1:0] rl);
        clear_ready_tasks();
        write_reg(CFG_IDLE_TASK, idle[CFG_W-1:0]);
        write_reg(CFG_SLICE_MIN, mn);
        write_reg(CFG_SLICE_RELOAD, rl);
    endtask

    function automatic logic signed [31:0] pick_slice();
        case ($urandom_range(7))
            0: return {1'b0, min_slice};
            1: return {1'b0, min_slice} + 1;
            2: return 32'sh8000_0000;
            3: return 32'sh7fff_ffff;
            4: return 0;
            5: return -1;
            default: return $urandom;
        endcase
    endfunction

    // directed corner cases, run under the reset configuration and again after a written one
    task automatic test_directed();
        send_op(OP_QUERY, 9, 3, 32'sh1234_5678);
        send_op(OP_REMOVE, 9, 0, 0);
        send_op(OP_CHANGE, 9, 31, 5);
        send_op(OP_ENQUEUE, 9, 31, 32'sh7fff_ffff);
        send_op(OP_ENQUEUE, 9, 4, 1);
        send_op(OP_ENQUEUE, 10, 31, 32'sh8000_0000);
        send_op(OP_ENQUEUE, 11, 31, 0);
        send_op(OP_ENQUEUE, 12, 31, 1);
        send_op(OP_ENQUEUE, 63, 0, -1);
        send_op(OP_ENQUEUE, 0, 0, 77);
        send_op(OP_CHANGE, 0, 1, 78);
        send_op(OP_QUERY, 0, 0, -5);
        send_op(OP_CHANGE, 11, 0, 100);
        send_op(OP_CHANGE, 12, 31, 0);
        send_op(OP_REMOVE, 63, 0, 3);
        send_op(OP_REMOVE, 11, 0, 3);
        send_op(OP_REMOVE, 12, 0, 3);
        send_op(OP_REMOVE, 10, 0, 3);
        send_op(OP_REMOVE, 9, 0, 3);
        send_op(OP_REMOVE, 0, 0, 3);
        send_op(OP_QUERY, 42, 21, 32'sh5555_aaaa);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [OP_W-1:0] op;
        int pick;
        int t;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 35) op = OP_ENQUEUE;
            else if (pick < 60) op = OP_REMOVE;
            else if (pick < 70) op = OP_QUERY;
            else op = OP_CHANGE;
            t = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(15);
            if ($urandom_range(9) == 0) t = int'(idle_id);
            send_op(op, t, $urandom_range(31), pick_slice());
        end
        wait_drained();
    endtask

    // receiver holds off while requests keep coming, then the sender pauses
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 30; i++)
            send_op(OP_ENQUEUE, i, i, (i % 2) ? -i : i * 1000);
        wait_drained();
        for (int i = 0; i < 30; i++)
            send_op(OP_REMOVE, i, 0, 0);
        wait_drained();
    endtask

    task automatic test_no_idling(int count);
        no_idling = 1'b1;
        test_random(count);
        no_idling = 1'b0;
    endtask

    // response checker and receiver stalls
    initial
    begin
        resp_t e;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_resp.size() == 0)
                begin
                    $display("%0t: response with nothing expected, top_task %0d",
                             $time, rsp_ch.top_task);
                    n_errors++;
                end
                else
                begin
                    e = pending_resp.pop_front();
                    n_checked++;
                    if (rsp_ch.top_task !== e.top_task || rsp_ch.top_is_idle !== e.top_is_idle
                        || rsp_ch.slice_out !== e.slice_out
                        || rsp_ch.was_ready !== e.was_ready || rsp_ch.error !== e.error)
                    begin
                        $display("%0t: expected top %0d idle %0b slice %0d was %0b err %0b",
                                 $time, e.top_task, e.top_is_idle, e.slice_out,
                                 e.was_ready, e.error);
                        $display("%0t: actual   top %0d idle %0b slice %0d was %0b err %0b",
                                 $time, rsp_ch.top_task, rsp_ch.top_is_idle,
                                 rsp_ch.slice_out, rsp_ch.was_ready, rsp_ch.error);
                        n_errors++;
                    end
                end
            end
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_cycles--;
            end
            else
                rsp_ch.ready = no_idling || ($urandom_range(99) >= 22);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
                $display("priority_bitmap_ready_queue_top: mismatch");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_QUERY;
        req_ch.task_req = '0;
        req_ch.level = '0;
        req_ch.slice_in = '0;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_err_flags = 0;
        hold_cycles = 0;
        no_idling = 1'b0;
        busy_map = '0;
        idle_id = IDLE_TASK_RST;
        min_slice = SLICE_MIN_RST;
        reload_slice = SLICE_RELOAD_RST;
        for (int t = 0; t < NTASK; t++) is_rdy[t] = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(400);
        test_backpressure();
        set_config(63, 31'h7fff_ffff, 31'h7fff_ffff);
        test_random(350);
        set_config(5, 31'd0, 31'd1);
        test_directed();
        test_no_idling(300);
        set_config($urandom_range(63), CFG_W'($urandom_range(2000)),
                   CFG_W'($urandom_range(5000) + 1));
        test_random(350);
        set_config(42, 31'h5555_5555, 31'h2aaa_aaaa);
        test_random(350);

        $display("covered %0d requests, %0d responses checked, %0d ready-task enqueues",
                 n_sent, n_checked, n_err_flags);
        $display("reset and four written register settings, receiver hold-off and sender pause");
        if (n_errors == 0 && pending_resp.size() == 0)
            $display("priority_bitmap_ready_queue_top: match");
        else
            $display("priority_bitmap_ready_queue_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
